[sv/eac_pkg.sv]
// Package for the expansion autoconfig chain responder.
// Holds the shared types, register offsets and image constants.
// No dependencies.
`default_nettype none

package eac_pkg;

    localparam int SLOT_COUNT = 5;
    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    localparam logic [1:0] CFG_FAST_SIZE = 2'd0;
    localparam logic [1:0] CFG_FSYS_EN = 2'd1;
    localparam logic [1:0] CFG_DIAG_ADDR = 2'd2;
    localparam logic [1:0] CFG_BOOT_ADDR = 2'd3;

    localparam logic [7:0] REG_BASE_HI = 8'h48;
    localparam logic [7:0] REG_BASE_LO = 8'h4a;
    localparam logic [7:0] REG_SHUTUP = 8'h4c;
    localparam logic [7:0] REG_CLEAR_A = 8'h30;
    localparam logic [7:0] REG_CLEAR_B = 8'h32;

    localparam logic [15:0] MFG_ID = 16'd2011;
    localparam logic [15:0] DIAG_BASE = 16'h1000;
    localparam logic [15:0] JMP_BASE = 16'h1100;
    localparam logic [7:0] OP_JMP_HI = 8'h4E;
    localparam logic [7:0] OP_JMP_LO = 8'hF9;

    typedef enum logic [1:0] {
        CARD_NONE = 2'd0,
        CARD_FAST = 2'd1,
        CARD_FSYS = 2'd2
    } card_t;

    typedef struct packed {
        logic [2:0]  fast_size_code;
        logic        filesys_enable;
        logic [31:0] diag_entry_addr;
        logic [31:0] boot_code_addr;
    } cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  access_size;
        logic [15:0] offset;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        card_t             card;
        card_t             card_after;
        logic [SLOT_W-1:0] slot;
        logic              past_end;
        logic              map_event;
        logic [7:0]        map_base_page;
    } chain_st_t;

    function automatic logic [7:0] diag_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'h90;
            3'd1: b = 8'h00;
            3'd2: b = 8'h01;
            3'd3: b = 8'h0C;
            3'd4: b = 8'h01;
            3'd5: b = 8'h00;
            3'd6: b = 8'h01;
            default: b = 8'h06;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[sv/eac_image.sv]
// Identity image lookup for the card in the current slot.
// Depends on eac_pkg.
`default_nettype none

module eac_image (
    input  eac_pkg::cfg_t  cfg,
    input  eac_pkg::card_t card,
    input  logic [15:0]    offset,
    output logic [7:0]     image_byte
);
    import eac_pkg::*;

    logic        fs;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_val;
    logic        reg_hit;
    logic [7:0]  nib;
    logic [3:0]  k;
    logic [2:0]  p;
    logic [31:0] jmp_addr;
    logic [7:0]  jmp_byte;

    assign fs = (card == CARD_FSYS);
    assign reg_addr = {offset[7:2], 2'b00};

    always_comb
    begin
        reg_hit = 1'b1;
        reg_val = 8'h00;
        case (reg_addr) inside
            8'h00:
            begin
                if (fs)
                    reg_val = 8'hd1;
                else
                begin
                    case (cfg.fast_size_code)
                        3'd1: reg_val = 8'he5;
                        3'd2: reg_val = 8'he6;
                        3'd3: reg_val = 8'he7;
                        default: reg_val = 8'he0;
                    endcase
                end
            end
            8'h04: reg_val = fs ? 8'h02 : 8'h01;
            8'h08: reg_val = fs ? 8'hc0 : 8'h80;
            8'h10: reg_val = MFG_ID[15:8];
            8'h14: reg_val = MFG_ID[7:0];
            8'h18, 8'h1c, 8'h20, 8'h2c, 8'h40: reg_val = 8'h00;
            8'h24: reg_val = 8'h01;
            8'h28: reg_val = fs ? 8'h10 : 8'h00;
            default: reg_hit = 1'b0;
        endcase
    end

    assign nib = offset[1] ? {reg_val[3:0], 4'h0} : {reg_val[7:4], 4'h0};

    assign k = offset[3:0];
    assign p = (k < 4'd6) ? k[2:0] : 3'(k - 4'd6);
    assign jmp_addr = (k < 4'd6) ? cfg.diag_entry_addr : cfg.boot_code_addr;

    always_comb
    begin
        case (p)
            3'd0: jmp_byte = OP_JMP_HI;
            3'd1: jmp_byte = OP_JMP_LO;
            3'd2: jmp_byte = jmp_addr[31:24];
            3'd3: jmp_byte = jmp_addr[23:16];
            3'd4: jmp_byte = jmp_addr[15:8];
            default: jmp_byte = jmp_addr[7:0];
        endcase
    end

    always_comb
    begin
        image_byte = 8'hff;
        if (card != CARD_NONE)
        begin
            if (offset < 16'h0044 && !offset[0])
            begin
                if (reg_hit)
                begin
                    if (reg_addr == 8'h00 || reg_addr == 8'h40)
                        image_byte = nib;
                    else
                        image_byte = ~nib;
                end
            end
            else if (fs)
            begin
                if (offset[15:3] == DIAG_BASE[15:3])
                    image_byte = diag_byte(offset[2:0]);
                else if (offset[15:4] == JMP_BASE[15:4] && k < 4'd12)
                    image_byte = jmp_byte;
            end
        end
    end

endmodule

`default_nettype wire

[sv/eac_chain.sv]
// Slot chain state: current slot, past-end flag and latched low base byte.
// Decodes byte writes and reports the card before and after each request.
// Depends on eac_pkg.
`default_nettype none

module eac_chain (
    input  logic              clk,
    input  logic              rst_n,
    input  eac_pkg::cfg_t     cfg,
    input  eac_pkg::req_t     req,
    input  logic              step,
    output eac_pkg::chain_st_t status
);
    import eac_pkg::*;

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              past_end_reg;
    logic              past_end_next;
    logic [7:0]        base_low_reg;
    logic [7:0]        base_low_next;
    card_t             card_now;
    logic              do_advance;
    logic              map_event;
    logic [7:0]        map_page;

    function automatic card_t card_at(input logic [SLOT_W-1:0] slot, input logic past,
                                      input cfg_t c);
        logic              fast;
        logic [SLOT_W-1:0] idx;
        card_t             r;
        fast = (c.fast_size_code >= 3'd1) && (c.fast_size_code <= 3'd4);
        idx = fast ? SLOT_W'(slot - 1'b1) : slot;
        r = CARD_NONE;
        if (!past)
        begin
            if (fast && slot == '0)
                r = CARD_FAST;
            else if (c.filesys_enable && idx == '0)
                r = CARD_FSYS;
        end
        return r;
    endfunction

    assign card_now = card_at(slot_reg, past_end_reg, cfg);

    always_comb
    begin
        base_low_next = base_low_reg;
        do_advance = 1'b0;
        map_event = 1'b0;
        map_page = 8'h00;
        if (req.cmd == CMD_WRITE && req.access_size == SIZE_BYTE)
        begin
            case (req.offset[7:0]) inside
                REG_CLEAR_A, REG_CLEAR_B: base_low_next = 8'h00;
                REG_BASE_LO: base_low_next = req.write_data;
                REG_BASE_HI:
                begin
                    do_advance = 1'b1;
                    if (card_now != CARD_NONE)
                    begin
                        map_event = 1'b1;
                        map_page = req.write_data | {4'h0, base_low_reg[7:4]};
                    end
                end
                REG_SHUTUP: do_advance = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        past_end_next = past_end_reg;
        if (do_advance && !past_end_reg)
        begin
            if (slot_reg == SLOT_LAST)
                past_end_next = 1'b1;
            else
                slot_next = SLOT_W'(slot_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            past_end_reg <= 1'b0;
            base_low_reg <= 8'h00;
        end
        else if (step)
        begin
            slot_reg <= slot_next;
            past_end_reg <= past_end_next;
            base_low_reg <= base_low_next;
        end
    end

    assign status.card = card_now;
    assign status.card_after = card_at(slot_next, past_end_next, cfg);
    assign status.slot = slot_reg;
    assign status.past_end = past_end_reg;
    assign status.map_event = map_event;
    assign status.map_base_page = map_page;

endmodule

`default_nettype wire

[sv/expansion_autoconfig_chain_core.sv]
// Expansion autoconfig chain responder: top level.
// Throughput is one request per cycle while m_tready does not stall the output;
// the input register and the result register form a two-stage pipe, and the
// slot state updates as a request moves from the first to the second.
// Reset clears the configuration registers, the slot chain and the base byte.
`default_nettype none

module expansion_autoconfig_chain_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // access_size[1:0], offset[17:2], write_data[25:18]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_data[31:0], map_event[32],
                                   // map_base_page[40:33], chain_empty[41]
    output logic        m_tuser,   // map_card
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import eac_pkg::*;

    cfg_t      cfg_reg;
    req_t      req_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    logic [31:0] read_data_reg;
    logic      map_event_reg;
    logic      map_card_reg;
    logic [7:0] map_page_reg;
    logic      chain_empty_reg;
    logic      step;
    logic [7:0] image_byte;
    logic [31:0] read_data_next;
    chain_st_t status;

    assign cfg_ready = 1'b1;
    assign step = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FAST_SIZE: cfg_reg.fast_size_code <= cfg_data[2:0];
                CFG_FSYS_EN:   cfg_reg.filesys_enable <= cfg_data[0];
                CFG_DIAG_ADDR: cfg_reg.diag_entry_addr <= cfg_data;
                CFG_BOOT_ADDR: cfg_reg.boot_code_addr <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg.cmd <= s_tuser;
            req_reg.access_size <= s_tdata[1:0];
            req_reg.offset <= s_tdata[17:2];
            req_reg.write_data <= s_tdata[25:18];
        end
    end

    eac_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .req    (req_reg),
        .step   (step),
        .status (status)
    );

    eac_image u_image (
        .cfg        (cfg_reg),
        .card       (status.card),
        .offset     (req_reg.offset),
        .image_byte (image_byte)
    );

    always_comb
    begin
        if (req_reg.cmd == CMD_WRITE)
            read_data_next = 32'h0;
        else if (req_reg.access_size == SIZE_BYTE)
            read_data_next = {24'h0, image_byte};
        else if (req_reg.access_size == SIZE_WORD)
            read_data_next = 32'h0000ffff;
        else
            read_data_next = 32'hffffffff;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            read_data_reg <= read_data_next;
            map_event_reg <= status.map_event;
            map_card_reg <= status.map_event && (status.card == CARD_FSYS);
            map_page_reg <= status.map_base_page;
            chain_empty_reg <= (status.card_after == CARD_NONE);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'h0, chain_empty_reg, map_page_reg, map_event_reg, read_data_reg};
    assign m_tuser = map_card_reg;

`ifndef SYNTHESIS
    a_past_end_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        status.past_end |-> (status.slot == SLOT_LAST && status.card == CARD_NONE))
        else $error("chain passed its end away from the last slot");

    a_no_map_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[32]) |-> (m_tdata[40:33] == 8'h00 && !m_tuser))
        else $error("map fields set without a map event");

    a_map_needs_card: assert property (@(posedge clk) disable iff (!rst_n)
        (step && status.map_event) |-> (status.card != CARD_NONE))
        else $error("map event on an empty slot");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result lost after a pipe step");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for expansion_autoconfig_chain_core: queued bus requests, an
// in-bench model of the slot chain and identity image, and random idling on both streams.
// Depends on eac_pkg and the core RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eac_pkg::*;

    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [15:0] MFR_ID = 16'd2011;
    localparam logic [63:0] DIAG_CODE = 64'h0601_0001_0C01_0090;

    typedef struct packed {
        logic [31:0] read_data;
        logic        map_event;
        logic        map_card;
        logic [7:0]  map_base_page;
        logic        chain_empty;
    } bus_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // access_size[1:0], offset[17:2], write_data[25:18]
    logic        s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // read_data[31:0], map_event[32],
                            // map_base_page[40:33], chain_empty[41]
    logic        m_tuser;   // map_card
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    req_t     access_q[$];
    bus_rsp_t resp_q[$];
    req_t     cur_req;
    bus_rsp_t want;
    bit       req_taken = 1'b0;
    int       cyc = 0;
    int       mismatches = 0;

    logic [2:0]  fast_sz = '0;
    logic        fsys_on = 1'b0;
    logic [31:0] diag_tgt = '0;
    logic [31:0] boot_tgt = '0;
    logic [2:0]  slot_q = '0;
    logic        past_end_q = 1'b0;
    logic [7:0]  base_lo = '0;

    expansion_autoconfig_chain_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic card_t card_now();
        logic [2:0] pos;
        logic fast;
        pos = slot_q;
        fast = (fast_sz >= 3'd1 && fast_sz <= 3'd4);
        if (past_end_q)
            return CARD_NONE;
        if (fast)
        begin
            if (pos == 3'd0)
                return CARD_FAST;
            pos = pos - 3'd1;
        end
        if (fsys_on && pos == 3'd0)
            return CARD_FSYS;
        return CARD_NONE;
    endfunction

    function automatic logic [7:0] id_reg_value(input card_t card, input logic [7:0] r,
                                                output logic hit);
        logic fs;
        logic [7:0] v;
        fs = (card == CARD_FSYS);
        hit = 1'b1;
        v = 8'h00;
        case (r) inside
            8'h00:
            begin
                if (fs)
                    v = 8'hd1;
                else
                    case (fast_sz)
                        3'd1: v = 8'he5;
                        3'd2: v = 8'he6;
                        3'd3: v = 8'he7;
                        default: v = 8'he0;
                    endcase
            end
            8'h04: v = fs ? 8'h02 : 8'h01;
            8'h08: v = fs ? 8'hc0 : 8'h80;
            8'h10: v = MFR_ID[15:8];
            8'h14: v = MFR_ID[7:0];
            8'h18, 8'h1c, 8'h20, 8'h2c, 8'h40: v = 8'h00;
            8'h24: v = 8'h01;
            8'h28: v = fs ? 8'h10 : 8'h00;
            default: hit = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] image_byte(input card_t card, input logic [15:0] off);
        logic hit;
        logic [7:0] v;
        logic [7:0] nib;
        logic [7:0] r;
        logic [31:0] tgt;
        int k;
        int p;
        if (card == CARD_NONE)
            return 8'hff;
        if (off < 16'h0044 && !off[0])
        begin
            r = {off[7:2], 2'b00};
            v = id_reg_value(card, r, hit);
            if (!hit)
                return 8'hff;
            nib = off[1] ? {v[3:0], 4'h0} : {v[7:4], 4'h0};
            if (r == 8'h00 || r == 8'h40)
                return nib;
            return ~nib;
        end
        if (card == CARD_FSYS)
        begin
            if (off >= DIAG_BASE && off < DIAG_BASE + 16'd8)
                return DIAG_CODE[8*off[2:0] +: 8];
            if (off >= JMP_BASE && off < JMP_BASE + 16'd12)
            begin
                k = int'(off - JMP_BASE);
                tgt = (k < 6) ? diag_tgt : boot_tgt;
                p = (k < 6) ? k : k - 6;
                if (p == 0)
                    return OP_JMP_HI;
                if (p == 1)
                    return OP_JMP_LO;
                return 8'(tgt >> (8 * (5 - p)));
            end
        end
        return 8'hff;
    endfunction

    function automatic void step_slot();
        if (!past_end_q)
        begin
            if (int'(slot_q) + 1 < SLOT_COUNT)
                slot_q = slot_q + 3'd1;
            else
                past_end_q = 1'b1;
        end
    endfunction

    function automatic bus_rsp_t predict_response(input req_t rq);
        bus_rsp_t rsp;
        card_t card;
        card = card_now();
        rsp = '0;
        if (rq.cmd == CMD_READ)
        begin
            if (rq.access_size == SIZE_BYTE)
                rsp.read_data = {24'd0, image_byte(card, rq.offset)};
            else if (rq.access_size == SIZE_WORD)
                rsp.read_data = 32'h0000_ffff;
            else
                rsp.read_data = 32'hffff_ffff;
        end
        else if (rq.access_size == SIZE_BYTE)
        begin
            case (rq.offset[7:0]) inside
                REG_CLEAR_A, REG_CLEAR_B: base_lo = 8'h00;
                REG_BASE_LO: base_lo = rq.write_data;
                REG_BASE_HI:
                begin
                    if (card != CARD_NONE)
                    begin
                        rsp.map_event = 1'b1;
                        rsp.map_card = (card == CARD_FSYS);
                        rsp.map_base_page = rq.write_data | (base_lo >> 4);
                    end
                    step_slot();
                end
                REG_SHUTUP: step_slot();
                default: ;
            endcase
        end
        rsp.chain_empty = (card_now() == CARD_NONE);
        return rsp;
    endfunction

    function automatic bit hold_off();
        if ((cyc % 2500) >= 2000)
            return 1'b0;
        return $urandom_range(99) < 37;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin
        cyc++;
        m_tready <= !hold_off();
        if (!s_tvalid || req_taken)
        begin
            if (access_q.size() != 0 && !hold_off())
            begin
                cur_req = access_q.pop_front();
                s_tdata <= {6'd0, cur_req.write_data, cur_req.offset, cur_req.access_size};
                s_tuser <= cur_req.cmd;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (resp_q.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %h", $time,
                             m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = resp_q.pop_front();
                    check_field("read_data", want.read_data, m_tdata[31:0]);
                    check_field("map_event", 32'(want.map_event), 32'(m_tdata[32]));
                    check_field("map_base_page", 32'(want.map_base_page), 32'(m_tdata[40:33]));
                    check_field("chain_empty", 32'(want.chain_empty), 32'(m_tdata[41]));
                    check_field("map_card", 32'(want.map_card), 32'(m_tuser));
                end
            end
            req_taken = s_tvalid && s_tready;
            if (req_taken)
                resp_q.push_back(predict_response(cur_req));
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_FAST_SIZE: fast_sz = val[2:0];
            CFG_FSYS_EN: fsys_on = val[0];
            CFG_DIAG_ADDR: diag_tgt = val;
            default: boot_tgt = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (access_q.size() != 0 || s_tvalid || resp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_access(input logic cmd, input logic [1:0] size, input logic [15:0] off,
                               input logic [7:0] data);
        req_t rq;
        rq.cmd = cmd;
        rq.access_size = size;
        rq.offset = off;
        rq.write_data = data;
        access_q.push_back(rq);
    endtask

    task automatic push_random(input int n, input bit may_advance);
        req_t rq;
        for (int i = 0; i < n; i++)
        begin
            rq.cmd = ($urandom_range(99) < 70) ? CMD_READ : CMD_WRITE;
            if ($urandom_range(99) < 75)
                rq.access_size = SIZE_BYTE;
            else
                rq.access_size = $urandom_range(1) ? SIZE_WORD : SIZE_LONG;
            case ($urandom_range(4))
                0: rq.offset = 16'($urandom);
                1: rq.offset = 16'($urandom_range(16'h0043));
                2: rq.offset = DIAG_BASE + 16'($urandom_range(15));
                3: rq.offset = JMP_BASE + 16'($urandom_range(15));
                default:
                begin
                    rq.offset[15:8] = 8'($urandom);
                    case ($urandom_range(4))
                        0: rq.offset[7:0] = REG_CLEAR_A;
                        1: rq.offset[7:0] = REG_CLEAR_B;
                        2: rq.offset[7:0] = REG_BASE_HI;
                        3: rq.offset[7:0] = REG_SHUTUP;
                        default: rq.offset[7:0] = REG_BASE_LO;
                    endcase
                end
            endcase
            rq.write_data = 8'($urandom);
            if (!may_advance && rq.cmd == CMD_WRITE && rq.access_size == SIZE_BYTE &&
                (rq.offset[7:0] == REG_BASE_HI || rq.offset[7:0] == REG_SHUTUP))
                rq.offset[7:0] = REG_BASE_LO;
            access_q.push_back(rq);
        end
    endtask

    task automatic set_chain(input logic [2:0] fast, input logic fsys, input logic [31:0] diag,
                             input logic [31:0] boot);
        wait_idle();
        write_reg(CFG_FAST_SIZE, 32'(fast));
        write_reg(CFG_FSYS_EN, 32'(fsys));
        write_reg(CFG_DIAG_ADDR, diag);
        write_reg(CFG_BOOT_ADDR, boot);
    endtask

    initial
    begin
        logic [15:0] probe_offs[21];
        probe_offs = '{16'h0000, 16'h0002, 16'h0004, 16'h0006, 16'h0010, 16'h0014, 16'h0028,
                       16'h002a, 16'h0040, 16'h0042, 16'h0044, 16'h0001, 16'h1000, 16'h1007,
                       16'h1100, 16'h1101, 16'h1102, 16'h1105, 16'h1106, 16'h110b, 16'hffff};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_access(CMD_READ, SIZE_BYTE, 16'h0000, 8'h00);
        push_access(CMD_READ, SIZE_WORD, 16'h0002, 8'h00);
        push_access(CMD_READ, SIZE_LONG, 16'hffff, 8'h00);

        set_chain(3'd0, 1'b1, 32'h0123_4567, 32'hfedc_ba98);
        foreach (probe_offs[i])
            push_access(CMD_READ, SIZE_BYTE, probe_offs[i], 8'h00);
        push_access(CMD_WRITE, SIZE_BYTE, {8'hff, REG_BASE_LO}, 8'hff);
        push_access(CMD_WRITE, SIZE_BYTE, {8'h00, REG_CLEAR_A}, 8'h00);
        push_access(CMD_WRITE, SIZE_BYTE, {8'h00, REG_CLEAR_B}, 8'h5a);
        push_access(CMD_WRITE, SIZE_WORD, {8'h00, REG_BASE_HI}, 8'hff);
        push_access(CMD_WRITE, SIZE_LONG, {8'h00, REG_SHUTUP}, 8'h00);

        set_chain(3'd1, 1'b0, 32'h0, 32'h0);
        push_random(80, 1'b0);
        set_chain(3'd2, 1'b1, 32'hffff_ffff, 32'h0);
        push_random(80, 1'b0);
        set_chain(3'd3, 1'b0, 32'h0, 32'hffff_ffff);
        push_random(80, 1'b0);
        set_chain(3'd4, 1'b1, 32'h0, 32'h0);
        push_random(80, 1'b0);
        set_chain(3'd0, 1'b1, 32'h0, 32'hffff_ffff);
        push_random(80, 1'b0);
        set_chain(3'd0, 1'b1, 32'hffff_ffff, 32'h0);
        push_random(80, 1'b0);
        set_chain(3'd5, 1'b1, $urandom, $urandom);
        push_random(80, 1'b0);
        set_chain(3'd7, 1'b1, $urandom, $urandom);
        push_random(80, 1'b0);
        set_chain(3'd6, 1'b0, $urandom, $urandom);
        push_random(60, 1'b0);
        for (int i = 0; i < 3; i++)
        begin
            set_chain(3'($urandom_range(7)), 1'($urandom), $urandom, $urandom);
            push_random(80, 1'b0);
        end

        // Walk the chain: map the fast card, map the filesystem card, then run off the end.
        set_chain(3'($urandom_range(1, 4)), 1'b1, $urandom, $urandom);
        push_access(CMD_WRITE, SIZE_BYTE, {8'($urandom), REG_BASE_LO}, 8'($urandom));
        push_access(CMD_READ, SIZE_BYTE, 16'h0000, 8'h00);
        push_access(CMD_WRITE, SIZE_BYTE, {8'($urandom), REG_BASE_HI}, 8'($urandom));
        push_random(25, 1'b0);
        push_access(CMD_WRITE, SIZE_BYTE, {8'h00, REG_CLEAR_B}, 8'h00);
        push_access(CMD_WRITE, SIZE_BYTE, {8'h00, REG_BASE_LO}, 8'($urandom));
        push_access(CMD_WRITE, SIZE_BYTE, {8'($urandom), REG_BASE_HI}, 8'($urandom));
        push_random(20, 1'b0);
        push_access(CMD_WRITE, SIZE_BYTE, {8'h00, REG_SHUTUP}, 8'h00);
        push_random(10, 1'b0);
        push_access(CMD_WRITE, SIZE_BYTE, {8'h00, REG_SHUTUP}, 8'h00);
        push_random(10, 1'b0);
        push_access(CMD_WRITE, SIZE_BYTE, {8'h00, REG_BASE_HI}, 8'($urandom));
        push_access(CMD_WRITE, SIZE_BYTE, {8'h00, REG_SHUTUP}, 8'h00);
        push_access(CMD_READ, SIZE_BYTE, 16'h0000, 8'h00);

        set_chain(3'd0, 1'b1, $urandom, $urandom);
        push_random(100, 1'b1);

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS expansion_autoconfig_chain_core");
        else
            $display("FAIL expansion_autoconfig_chain_core");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL expansion_autoconfig_chain_core");
        $finish;
    end
endmodule
